@@ sv/bpa_pkg.sv @@
// bitmap page allocator: shared constants, types and helper functions
// used by the page map, the pool bitmap and the top level; no dependencies
package bpa_pkg;

  // sizes of the map and the pool
  localparam int VIRTUAL_PAGES   = 4096;
  localparam int BITMAP_WORDS    = 16;
  localparam int ALLOC_LIMIT     = 1024;
  localparam int WORD_BITS       = 64;
  localparam int BIT_IDX_W       = $clog2(WORD_BITS);
  localparam int MAP_AW          = $clog2(VIRTUAL_PAGES);
  localparam int WORD_AW         = $clog2(BITMAP_WORDS);
  localparam int PHYS_W          = WORD_AW + BIT_IDX_W;
  localparam int ENTRY_W         = PHYS_W + 1;
  localparam int CNT_W           = $clog2(ALLOC_LIMIT + 1);

  // beat fields
  localparam int VPAGE_W         = 12;
  localparam int PAGE_BYTES_W    = 21;
  localparam int OFFSET_W        = 32;
  localparam int STATUS_W        = 2;
  localparam int PHYS_OUT_W      = 10;
  localparam int S_TDATA_W       = 16;
  localparam int M_TDATA_W       = 48;

  localparam logic [PAGE_BYTES_W-1:0] PAGE_BYTES_RESET = PAGE_BYTES_W'(65536);

  // result codes
  localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_BIT,
    S_OUT
  } state_t;

  // access to the virtual page map
  typedef struct packed {
    logic               rd_en;
    logic [MAP_AW-1:0]  rd_addr;
    logic               wr_en;
    logic [MAP_AW-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } map_req_t;

  // access to the pool bitmap
  typedef struct packed {
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } pool_req_t;

  // index counted from the msb of the first zero bit, two-level search
  function automatic logic [BIT_IDX_W-1:0] first_zero_msb(input logic [WORD_BITS-1:0] word);
    logic [WORD_BITS-1:0] z;
    logic [7:0]           grp_any;
    logic [2:0]           grp;
    logic [2:0]           sub;
    int                   g;
    int                   b;
    for (b = 0; b < WORD_BITS; b++) begin
      z[b] = ~word[WORD_BITS-1-b];
    end
    for (g = 0; g < 8; g++) begin
      grp_any[g] = |z[8*g +: 8];
    end
    grp = 3'd7;
    for (g = 7; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp = 3'(g);
      end
    end
    sub = 3'd7;
    for (b = 7; b >= 0; b--) begin
      if (z[{grp, 3'(b)}]) begin
        sub = 3'(b);
      end
    end
    return {grp, sub};
  endfunction

endpackage

@@ sv/bitmap_page_allocator.sv @@
// bitmap page allocator top level: control sequencer, allocation count,
// page size register and output register; uses bpa_pkg, bpa_page_map, bpa_pool
//
// sequencing: an input beat is looked up in the map in S_MAP; alloc and free then do
//   the bitmap read-modify-write in S_BIT, and every result passes S_OUT to the output
//   register; both memories have registered reads, and a new beat is taken only in S_IDLE
// reset: the map is cleared by a pass over all 4096 entries after rst (no input taken),
//   bitmap flags and the count clear at once, page size resets to 65536
module bitmap_page_allocator (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: virtual_page[11:0], zero fill
  input  logic [bpa_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: want
  input  logic                            s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // m_tdata: physical_page[9:0], image_offset[41:10], zero fill
  output logic [bpa_pkg::M_TDATA_W-1:0]   m_tdata,
  // m_tuser: status[1:0]
  output logic [bpa_pkg::STATUS_W-1:0]    m_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // image page bytes register write
  input  logic [bpa_pkg::PAGE_BYTES_W-1:0] cfg_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready
);

  bpa_pkg::state_t state, state_next;

  // per-item registers
  logic [bpa_pkg::VPAGE_W-1:0]      vpage_q;
  logic                             want_q;
  logic [bpa_pkg::OFFSET_W-1:0]     offset_q;
  logic [bpa_pkg::WORD_AW-1:0]      word_q;
  logic [bpa_pkg::PHYS_W-1:0]       phys_q;
  logic [bpa_pkg::STATUS_W-1:0]     status_q;
  logic [bpa_pkg::PHYS_OUT_W-1:0]   res_phys_q;

  logic [bpa_pkg::CNT_W-1:0]        used_count;
  logic [bpa_pkg::PAGE_BYTES_W-1:0] page_bytes;
  logic [bpa_pkg::MAP_AW-1:0]       clr_addr;

  // memory ports
  bpa_pkg::map_req_t                map_req;
  bpa_pkg::pool_req_t               pool_req;
  logic [bpa_pkg::ENTRY_W-1:0]      map_entry;
  logic [bpa_pkg::WORD_BITS-1:0]    pool_word;
  logic                             pool_any_free;
  logic [bpa_pkg::WORD_AW-1:0]      pool_first_free;

  // decode of the map entry that arrives in S_MAP
  logic                             ent_mapped;
  logic [bpa_pkg::PHYS_W-1:0]       ent_phys;
  logic                             in_range;
  logic                             do_alloc;
  logic                             do_free;
  logic                             pool_short;

  // bitmap update in S_BIT
  logic [bpa_pkg::BIT_IDX_W-1:0]    alloc_bit;
  logic [bpa_pkg::BIT_IDX_W-1:0]    bit_sel;
  logic [bpa_pkg::WORD_BITS-1:0]    bit_mask;

  logic [bpa_pkg::VPAGE_W+bpa_pkg::PAGE_BYTES_W-1:0] product;
  logic                             out_load;

  bpa_page_map u_map (
    .clk     (clk),
    .req     (map_req),
    .rd_data (map_entry)
  );

  bpa_pool u_pool (
    .clk        (clk),
    .rst        (rst),
    .req        (pool_req),
    .rd_word    (pool_word),
    .any_free   (pool_any_free),
    .first_free (pool_first_free)
  );

  assign ent_mapped = map_entry[bpa_pkg::ENTRY_W-1];
  assign ent_phys   = map_entry[bpa_pkg::PHYS_W-1:0];
  assign in_range   = 32'(vpage_q) < 32'(bpa_pkg::VIRTUAL_PAGES);
  assign do_alloc   = in_range && want_q && !ent_mapped;
  assign do_free    = in_range && !want_q && ent_mapped;
  assign pool_short = (used_count >= bpa_pkg::CNT_W'(bpa_pkg::ALLOC_LIMIT))
                      || !pool_any_free;

  // pool page j*64+k lives at bit 63-k of word j
  assign alloc_bit = bpa_pkg::first_zero_msb(pool_word);
  assign bit_sel   = want_q ? alloc_bit : phys_q[bpa_pkg::BIT_IDX_W-1:0];
  assign bit_mask  = bpa_pkg::WORD_BITS'(1) << (~bit_sel);

  // image offset, registered before use, wraps to 32 bits
  assign product   = bpa_pkg::VPAGE_W'(vpage_q) * page_bytes;

  // config always taken; writes must only happen while idle, the block itself does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= bpa_pkg::PAGE_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      page_bytes <= cfg_data;
    end
  end

  // sequencer: next state and memory strobes
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    map_req    = '0;
    pool_req   = '0;
    unique case (state)
      bpa_pkg::S_CLEAR: begin
        // one map entry a cycle back to unmapped
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = clr_addr;
        map_req.wr_data = '0;
        if (clr_addr == bpa_pkg::MAP_AW'(bpa_pkg::VIRTUAL_PAGES - 1)) begin
          state_next = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_IDLE: begin
        s_tready        = 1'b1;
        map_req.rd_addr = s_tdata[bpa_pkg::MAP_AW-1:0];
        if (s_tvalid) begin
          map_req.rd_en = 1'b1;
          state_next    = bpa_pkg::S_MAP;
        end
      end
      bpa_pkg::S_MAP: begin
        if (do_alloc && !pool_short) begin
          pool_req.rd_en   = 1'b1;
          pool_req.rd_addr = pool_first_free;
          state_next       = bpa_pkg::S_BIT;
        end else if (do_free) begin
          pool_req.rd_en   = 1'b1;
          pool_req.rd_addr = ent_phys[bpa_pkg::PHYS_W-1:bpa_pkg::BIT_IDX_W];
          state_next       = bpa_pkg::S_BIT;
        end else begin
          state_next = bpa_pkg::S_OUT;
        end
      end
      bpa_pkg::S_BIT: begin
        // read-modify-write of the bitmap word, map entry updated alongside
        pool_req.wr_en   = 1'b1;
        pool_req.wr_addr = word_q;
        pool_req.wr_data = want_q ? (pool_word | bit_mask) : (pool_word & ~bit_mask);
        map_req.wr_en    = 1'b1;
        map_req.wr_addr  = vpage_q[bpa_pkg::MAP_AW-1:0];
        map_req.wr_data  = want_q ? {1'b1, word_q, alloc_bit} : '0;
        state_next       = bpa_pkg::S_OUT;
      end
      bpa_pkg::S_OUT: begin
        // hand the result to the output register once it is free
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == bpa_pkg::S_CLEAR) begin
      clr_addr <= clr_addr + bpa_pkg::MAP_AW'(1);
    end
  end

  // allocation count
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (state == bpa_pkg::S_BIT) begin
      if (want_q) begin
        used_count <= used_count + bpa_pkg::CNT_W'(1);
      end else if (used_count != '0) begin
        used_count <= used_count - bpa_pkg::CNT_W'(1);
      end
    end
  end

  // per-item payload registers
  always_ff @(posedge clk) begin
    case (state)
      bpa_pkg::S_IDLE: begin
        vpage_q <= s_tdata[bpa_pkg::VPAGE_W-1:0];
        want_q  <= s_tuser;
      end
      bpa_pkg::S_MAP: begin
        offset_q   <= product[bpa_pkg::OFFSET_W-1:0];
        phys_q     <= ent_phys;
        res_phys_q <= '0;
        word_q     <= do_alloc ? pool_first_free
                               : ent_phys[bpa_pkg::PHYS_W-1:bpa_pkg::BIT_IDX_W];
        if (do_alloc && pool_short) begin
          status_q <= bpa_pkg::ST_NO_SPACE;
        end else begin
          status_q <= bpa_pkg::ST_UNCHANGED;
        end
      end
      bpa_pkg::S_BIT: begin
        if (want_q) begin
          status_q   <= bpa_pkg::ST_ALLOCATED;
          res_phys_q <= bpa_pkg::PHYS_OUT_W'({word_q, alloc_bit});
        end else begin
          status_q   <= bpa_pkg::ST_FREED;
          res_phys_q <= bpa_pkg::PHYS_OUT_W'(phys_q);
        end
      end
      default: begin
      end
    endcase
  end

  // output register, holds a beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= status_q;
      m_tdata <= {(bpa_pkg::M_TDATA_W - bpa_pkg::OFFSET_W - bpa_pkg::PHYS_OUT_W)'(0),
                  (status_q == bpa_pkg::ST_ALLOCATED) ? offset_q : '0,
                  res_phys_q};
    end
  end

  // checks
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    used_count <= bpa_pkg::CNT_W'(bpa_pkg::ALLOC_LIMIT))
    else $error("allocation count above limit");

  a_accept_reads_map: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == bpa_pkg::S_MAP)
    else $error("accepted beat did not start a map lookup");

  a_offset_only_alloc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != bpa_pkg::ST_ALLOCATED |-> m_tdata[41:10] == '0)
    else $error("image offset set on a non-allocating result");

  a_phys_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == bpa_pkg::ST_UNCHANGED || m_tuser == bpa_pkg::ST_NO_SPACE)
    |-> m_tdata[9:0] == '0)
    else $error("physical page set without allocation or free");

endmodule

@@ sv/bpa_page_map.sv @@
// virtual page map memory: mapped flag and pool page per virtual page
// one write and one registered read per cycle; uses bpa_pkg
module bpa_page_map (
  input  logic                        clk,
  input  bpa_pkg::map_req_t           req,
  output logic [bpa_pkg::ENTRY_W-1:0] rd_data
);

  logic [bpa_pkg::ENTRY_W-1:0] mem [bpa_pkg::VIRTUAL_PAGES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ sv/bpa_pool.sv @@
// pool bitmap memory with per-word valid and full flags
// gives the first word with a free page; uses bpa_pkg
module bpa_pool (
  input  logic                          clk,
  input  logic                          rst,
  input  bpa_pkg::pool_req_t            req,
  output logic [bpa_pkg::WORD_BITS-1:0] rd_word,
  output logic                          any_free,
  output logic [bpa_pkg::WORD_AW-1:0]   first_free
);

  logic [bpa_pkg::WORD_BITS-1:0] mem [bpa_pkg::BITMAP_WORDS];
  logic [bpa_pkg::WORD_BITS-1:0] rd_q;
  logic                          rd_vld;
  logic [bpa_pkg::BITMAP_WORDS-1:0] vld;
  logic [bpa_pkg::BITMAP_WORDS-1:0] full;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // a word never written reads as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      full   <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr]  <= 1'b1;
        full[req.wr_addr] <= &req.wr_data;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.rd_addr];
      end
    end
  end

  assign rd_word  = rd_vld ? rd_q : '0;
  assign any_free = ~&full;

  always_comb begin
    first_free = '0;
    for (int i = bpa_pkg::BITMAP_WORDS - 1; i >= 0; i--) begin
      if (!full[i]) begin
        first_free = bpa_pkg::WORD_AW'(i);
      end
    end
  end

endmodule
